// ----- hw/rtl/sle_pkg.sv -----
// shared types, constants and the echo text table for the console line editor
// no dependencies; used by sle_ctrl, sle_datapath and serial_console_line_editor
package sle_pkg;

    // line discarded once it grows to this many bytes
    localparam int LINE_LIMIT = 14;
    // stored length never exceeds LINE_LIMIT-1
    localparam int LEN_W      = $clog2(LINE_LIMIT);
    localparam int CMDLEN_W   = 4;
    localparam int TXT_W      = 6;

    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_ETX = 8'h03;
    localparam logic [7:0] CHAR_DEL = 8'h7f;
    localparam logic [7:0] CHAR_ESC = 8'h1b;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // text table layout: too-long message (its first two chars double as CR LF),
    // then ^C CR LF, BS space BS, and the escape spelling
    localparam logic [TXT_W-1:0] TXT_LONG_START  = 6'd0;
    localparam logic [TXT_W-1:0] TXT_CRLF_END    = 6'd1;
    localparam logic [TXT_W-1:0] TXT_LONG_END    = 6'd22;
    localparam logic [TXT_W-1:0] TXT_ETX_START   = 6'd23;
    localparam logic [TXT_W-1:0] TXT_ETX_END     = 6'd26;
    localparam logic [TXT_W-1:0] TXT_BS_START    = 6'd27;
    localparam logic [TXT_W-1:0] TXT_BS_END      = 6'd29;
    localparam logic [TXT_W-1:0] TXT_ESC_START   = 6'd30;
    localparam logic [TXT_W-1:0] TXT_ESC_END     = 6'd33;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_CR    = 3'd1,
        CLS_ETX   = 3'd2,
        CLS_BS    = 3'd3,
        CLS_ESC   = 3'd4
    } cls_t;

    typedef enum logic [1:0] {
        EMIT_TEXT = 2'd0,
        EMIT_CMD  = 2'd1,
        EMIT_DONE = 2'd2,
        EMIT_ECHO = 2'd3
    } emit_t;

    typedef struct packed {
        logic  accept;
        logic  emit_en;
        emit_t emit_sel;
        logic  last;
    } sle_cmd_t;

    typedef struct packed {
        cls_t live_cls;
        cls_t held_cls;
        logic held_ovf;
        logic txt_last;
        logic idx_last;
        logic len_zero;
        logic out_free;
    } sle_stat_t;

    function automatic logic [7:0] text_char(input logic [TXT_W-1:0] p);
        logic [7:0] c;
        unique case (p)
            6'd0:    c = 8'h0d;
            6'd1:    c = 8'h0a;
            6'd2:    c = "T";
            6'd3:    c = "o";
            6'd4:    c = "o";
            6'd5:    c = " ";
            6'd6:    c = "l";
            6'd7:    c = "o";
            6'd8:    c = "n";
            6'd9:    c = "g";
            6'd10:   c = " ";
            6'd11:   c = "a";
            6'd12:   c = " ";
            6'd13:   c = "c";
            6'd14:   c = "o";
            6'd15:   c = "m";
            6'd16:   c = "m";
            6'd17:   c = "a";
            6'd18:   c = "n";
            6'd19:   c = "d";
            6'd20:   c = "!";
            6'd21:   c = 8'h0d;
            6'd22:   c = 8'h0a;
            6'd23:   c = "^";
            6'd24:   c = "C";
            6'd25:   c = 8'h0d;
            6'd26:   c = 8'h0a;
            6'd27:   c = 8'h08;
            6'd28:   c = " ";
            6'd29:   c = 8'h08;
            6'd30:   c = "\\";
            6'd31:   c = "x";
            6'd32:   c = "1";
            6'd33:   c = "b";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/sle_ctrl.sv -----
// sequencing state machine of the console line editor
// depends on sle_pkg; drives sle_datapath through sle_cmd_t
module sle_ctrl import sle_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sle_stat_t stat,
    output sle_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TEXT = 5'b00010,
        ST_CMD  = 5'b00100,
        ST_DONE = 5'b01000,
        ST_ECHO = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.emit_en  = 1'b0;
        cmd.emit_sel = EMIT_ECHO;
        cmd.last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (stat.live_cls == CLS_OTHER) ? ST_ECHO : ST_TEXT;
                end
            end
            ST_TEXT: begin
                cmd.emit_sel = EMIT_TEXT;
                if (stat.out_free) begin
                    cmd.emit_en = 1'b1;
                    if (stat.txt_last) begin
                        cmd.last = (stat.held_cls != CLS_CR);
                        if (stat.held_cls == CLS_CR) begin
                            state_next = stat.len_zero ? ST_DONE : ST_CMD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CMD: begin
                cmd.emit_sel = EMIT_CMD;
                if (stat.out_free) begin
                    cmd.emit_en = 1'b1;
                    if (stat.idx_last) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                cmd.emit_sel = EMIT_DONE;
                if (stat.out_free) begin
                    cmd.emit_en = 1'b1;
                    cmd.last    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_ECHO: begin
                cmd.emit_sel = EMIT_ECHO;
                if (stat.out_free) begin
                    cmd.emit_en = 1'b1;
                    cmd.last    = !stat.held_ovf;
                    state_next  = stat.held_ovf ? ST_TEXT : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sle_datapath.sv -----
// line store, length, text pointer, command index and result register
// depends on sle_pkg; controlled by sle_ctrl through sle_cmd_t
module sle_datapath import sle_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_rx_byte,
    input  logic                m_ready,
    input  sle_cmd_t            cmd,
    output sle_stat_t           stat,
    output logic                m_valid,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic [CMDLEN_W-1:0] m_command_length,
    output logic                m_last
);

    logic [7:0]          store_reg [LINE_LIMIT];
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    idx_reg;
    logic [TXT_W-1:0]    ptr_reg;
    logic [TXT_W-1:0]    end_reg;
    logic [7:0]          byte_reg;
    cls_t                cls_reg;
    logic                ovf_reg;

    logic                m_valid_reg;
    logic [1:0]          m_kind_reg;
    logic [7:0]          m_data_reg;
    logic [CMDLEN_W-1:0] m_len_reg;
    logic                m_last_reg;

    cls_t                live_cls;
    logic                live_ovf;

    always_comb begin
        if (s_rx_byte == CHAR_CR) begin
            live_cls = CLS_CR;
        end else if (s_rx_byte == CHAR_ETX) begin
            live_cls = CLS_ETX;
        end else if (s_rx_byte == CHAR_DEL && len_reg != '0) begin
            live_cls = CLS_BS;
        end else if (s_rx_byte == CHAR_ESC) begin
            live_cls = CLS_ESC;
        end else begin
            live_cls = CLS_OTHER;
        end
    end

    // storing this byte would fill the line
    assign live_ovf = (live_cls == CLS_OTHER) && (s_rx_byte != 8'h00) &&
                      (len_reg == LEN_W'(LINE_LIMIT - 1));

    assign stat.live_cls = live_cls;
    assign stat.held_cls = cls_reg;
    assign stat.held_ovf = ovf_reg;
    assign stat.txt_last = (ptr_reg == end_reg);
    assign stat.idx_last = (LEN_W'(idx_reg + 1'b1) == len_reg);
    assign stat.len_zero = (len_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    // line store: no reset, only entries below the length are ever read
    always_ff @(posedge aclk) begin
        if (cmd.accept && live_cls == CLS_OTHER && s_rx_byte != 8'h00) begin
            store_reg[len_reg] <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd.accept) begin
            case (live_cls)
                CLS_ETX: len_reg <= '0;
                CLS_BS:  len_reg <= len_reg - 1'b1;
                CLS_OTHER: begin
                    if (live_ovf) begin
                        len_reg <= '0;
                    end else if (s_rx_byte != 8'h00) begin
                        len_reg <= len_reg + 1'b1;
                    end
                end
                default: len_reg <= len_reg;
            endcase
        end else if (cmd.emit_en && cmd.emit_sel == EMIT_DONE) begin
            len_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_rx_byte;
            cls_reg  <= live_cls;
            ovf_reg  <= live_ovf;
            idx_reg  <= '0;
            case (live_cls)
                CLS_CR: begin
                    ptr_reg <= TXT_LONG_START;
                    end_reg <= TXT_CRLF_END;
                end
                CLS_ETX: begin
                    ptr_reg <= TXT_ETX_START;
                    end_reg <= TXT_ETX_END;
                end
                CLS_BS: begin
                    ptr_reg <= TXT_BS_START;
                    end_reg <= TXT_BS_END;
                end
                CLS_ESC: begin
                    ptr_reg <= TXT_ESC_START;
                    end_reg <= TXT_ESC_END;
                end
                default: begin
                    ptr_reg <= TXT_LONG_START;
                    end_reg <= TXT_LONG_END;
                end
            endcase
        end else if (cmd.emit_en) begin
            if (cmd.emit_sel == EMIT_TEXT) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.emit_sel == EMIT_CMD) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_en) begin
            m_last_reg <= cmd.last;
            case (cmd.emit_sel)
                EMIT_TEXT: begin
                    m_kind_reg <= KIND_ECHO;
                    m_data_reg <= text_char(ptr_reg);
                    m_len_reg  <= '0;
                end
                EMIT_CMD: begin
                    m_kind_reg <= KIND_CMD;
                    m_data_reg <= store_reg[idx_reg];
                    m_len_reg  <= '0;
                end
                EMIT_DONE: begin
                    m_kind_reg <= KIND_DONE;
                    m_data_reg <= 8'h00;
                    m_len_reg  <= CMDLEN_W'(len_reg);
                end
                default: begin
                    m_kind_reg <= KIND_ECHO;
                    m_data_reg <= byte_reg;
                    m_len_reg  <= '0;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_data_byte      = m_data_reg;
    assign m_command_length = m_len_reg;
    assign m_last           = m_last_reg;

    a_len_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(LINE_LIMIT - 1))
        else $error("line length reached the limit");

    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_en |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_accept_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !cmd.emit_en)
        else $error("byte taken while a result is being produced");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_en && cmd.emit_sel == EMIT_DONE) |=> (len_reg == '0))
        else $error("line not cleared after command complete");

endmodule

// ----- hw/rtl/serial_console_line_editor.sv -----
// Console line editor: one received byte in, echo and command words out.
// s_valid/s_ready/s_rx_byte take one console byte per word. m_valid/m_ready
// carry result words: m_kind (echo, command byte, command complete),
// m_data_byte, m_command_length and m_last, set on the final word of a byte.
// A byte is taken only while the sequencer is idle; the sequencer then leaves
// idle and loads its first result word into the result register, and further
// words follow one per cycle while that register is free, from the text table,
// the line store or the held byte. A plain echo gives one word, a byte that
// fills the line gives the echo plus the 23-character too-long message, and
// a carriage return gives CR LF, the stored bytes and a command-complete word.
// The result register is the only buffer: while m_ready is low the sequencer
// stalls with the word held, and a new byte is taken as soon as the last word
// of the previous one has been loaded, even if it is still waiting to be taken.
// Reset (aresetn low, synchronous) empties the line and the result register;
// the line store itself is not cleared, as unused entries are never read.
// Depends on sle_pkg, sle_ctrl and sle_datapath.
module serial_console_line_editor import sle_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic [CMDLEN_W-1:0] m_command_length,
    output logic                m_last
);

    sle_cmd_t  cmd;
    sle_stat_t stat;

    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sle_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rx_byte        (s_rx_byte),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_command_length (m_command_length),
        .m_last           (m_last)
    );

endmodule
